/* hw/rtl/warp_grid_bicubic_eval_assert.svh */
// Assertion macros shared by the warp grid evaluator.
`ifndef WARP_GRID_BICUBIC_EVAL_ASSERT_SVH
`define WARP_GRID_BICUBIC_EVAL_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WGBE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WGBE_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/wgbe_pkg.sv */
`timescale 1ns / 1ps
package wgbe_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int PT_W       = 18;
    localparam int OUT_W      = 24;
    localparam int VAL_W      = 40;
    localparam int DEPTH      = 64;
    localparam int ADDR_W     = 6;
    localparam int GRID_W     = 8;
    localparam int SUB_W      = 3;
    localparam int NUM_W      = GRID_W + SUB_W;
    localparam int QUOT_W     = SUB_W + FRAC_BITS;
    localparam int VNUM_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int OUT_MAX    = (1 << (OUT_W - 1)) - 1;
    localparam int OUT_MIN    = -(1 << (OUT_W - 1));

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_EVAL  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_COLS  = 3'd0,
        REG_GRID_ROWS  = 3'd1,
        REG_SUBDIV_X   = 3'd2,
        REG_SUBDIV_Y   = 3'd3,
        REG_CUBIC_MODE = 3'd4
    } cfg_reg_t;

    typedef logic signed [VAL_W-1:0] val_t;
    typedef val_t [3:0] knots_t;

    // A coordinate outside the grid resolves to at most two stored points.
    typedef struct packed {
        logic [SUB_W-1:0]        i0;
        logic signed [2:0]       w0;
        logic [SUB_W-1:0]        i1;
        logic signed [2:0]       w1;
        logic                    two;
    } mirror_t;

    typedef struct packed {
        logic                    start;
        logic                    cubic;
        logic [FRAC_BITS-1:0]    t;
    } interp_req_t;

    // Mirror extrapolation of one axis: beyond an edge the point is twice
    // the edge minus the reflected point, applied again when the reflection
    // itself falls off the far edge of a one-cell grid.
    function automatic mirror_t mirror(input logic signed [4:0] c, input logic [SUB_W-1:0] s);
        mirror_t m;
        logic signed [4:0] ss;
        ss    = $signed({2'b00, s});
        m     = '0;
        m.i0  = c[SUB_W-1:0];
        m.w0  = 3'sd1;
        if (c < 5'sd0) begin
            m.i0 = '0;            m.w0 = 3'sd2;
            m.i1 = SUB_W'(1);     m.w1 = -3'sd1;
            m.two = 1'b1;
        end else if (c == ss + 5'sd1) begin
            m.i0 = s;             m.w0 = 3'sd2;
            m.i1 = s - SUB_W'(1); m.w1 = -3'sd1;
            m.two = 1'b1;
        end else if (c > ss + 5'sd1) begin
            m.two = 1'b1;
            if (s == SUB_W'(1)) begin
                m.i0 = SUB_W'(1); m.w0 = 3'sd3;
                m.i1 = '0;        m.w1 = -3'sd2;
            end else begin
                m.i0 = s;             m.w0 = 3'sd2;
                m.i1 = s - SUB_W'(2); m.w1 = -3'sd1;
            end
        end
        return m;
    endfunction

    // Store contents after reset: the unit square corners, all else zero.
    function automatic logic [2*PT_W-1:0] reset_point(input logic [ADDR_W-1:0] a);
        logic [PT_W-1:0] one;
        logic [2*PT_W-1:0] r;
        one = PT_W'(1 << FRAC_BITS);
        r   = '0;
        case (a)
            ADDR_W'(0): r = {{PT_W{1'b0}}, one};
            ADDR_W'(1): r = {one, one};
            ADDR_W'(3): r = {one, {PT_W{1'b0}}};
            default:    r = '0;
        endcase
        return r;
    endfunction

endpackage

/* hw/rtl/warp_grid_bicubic_eval.sv */
// Mesh warp evaluator over a grid of control points.
// Input channel (s_*): one beat is either a control point write (action 0),
// which updates the point store and gives no result, or an evaluate
// request (action 1) for one mesh vertex, which gives exactly one result
// beat on the output channel (m_*) carrying the warped position, the
// vertex number and a saturation flag.
// Write beats can follow back to back. An evaluate beat first runs the grid
// mapping divider, then reads the point store one entry per cycle: 16 reads
// for a bicubic vertex inside the grid, up to 4 reads per knot near an edge
// (36 at most), 4 to 9 for bilinear. The knots read for one column (one row
// for bilinear) are interpolated for each coordinate before the next ones are
// read, and a last interpolation across them gives the result. The input is
// ready again in the cycle after the result is loaded. Store reads go through
// the single read port and interpolation steps through the shared multiplier.
// The output register holds a finished result while the next beat is taken
// in; if the receiver stalls with a result already waiting, the block holds
// its next result, and takes no new beat, until the register is free.
// Reset restores the registers and makes the store read as the unit
// square corners with all other entries zero; no clearing pass is needed.
`timescale 1ns / 1ps
`include "warp_grid_bicubic_eval_assert.svh"
module warp_grid_bicubic_eval (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [wgbe_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wgbe_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_action,
    input  logic [wgbe_pkg::ADDR_W-1:0]         s_point_index,
    input  logic signed [wgbe_pkg::PT_W-1:0]    s_point_x,
    input  logic signed [wgbe_pkg::PT_W-1:0]    s_point_y,
    input  logic [wgbe_pkg::GRID_W-1:0]         s_vertex_col,
    input  logic [wgbe_pkg::GRID_W-1:0]         s_vertex_row,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [wgbe_pkg::OUT_W-1:0]   m_warped_x,
    output logic signed [wgbe_pkg::OUT_W-1:0]   m_warped_y,
    output logic [wgbe_pkg::VNUM_W-1:0]         m_vertex_number,
    output logic                                m_saturated
);
    import wgbe_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DIV, ST_ISSUE, ST_LAND, ST_INNER_X, ST_INNER_Y,
        ST_OUTER_X, ST_OUTER_Y, ST_DONE
    } state_t;

    // Configuration registers.
    logic [GRID_W-1:0] grid_cols_reg, grid_rows_reg;
    logic [SUB_W-1:0]  subdiv_x_reg, subdiv_y_reg;
    logic              cubic_mode_reg;

    // Values actually used: zero sizes act as one, and vertex coordinates clamp to the grid size.
    logic [GRID_W-1:0] gc_eff, gr_eff, vc_eff, vr_eff;
    logic [SUB_W-1:0]  sx_eff, sy_eff;

    state_t                state_reg;
    logic [SUB_W-1:0]      col_reg, row_reg;
    logic [FRAC_BITS-1:0]  fu_reg, fv_reg;
    logic [1:0]            o_reg, n_reg;
    logic                  tx_reg, ty_reg;
    logic [VNUM_W-1:0]     vnum_reg;
    logic [DEPTH-1:0]      vld_reg;

    // Read pipeline: what travels with each store read.
    logic                  p_valid_reg, p_first_reg, p_last_reg, pv_reg;
    logic signed [4:0]     p_w_reg;
    logic [1:0]            p_n_reg;
    logic [ADDR_W-1:0]     p_addr_reg;
    val_t                  accx_reg, accy_reg;

    knots_t                kx_reg, ky_reg, ax_reg, ay_reg;
    val_t                  resx_reg, resy_reg;
    logic                  istart_reg;

    logic                  m_valid_reg, m_sat_reg;
    logic signed [OUT_W-1:0] m_x_reg, m_y_reg;
    logic [VNUM_W-1:0]     m_vnum_reg;

    logic                  s_fire, eval_fire, ram_we, rd_en, out_load;
    logic [NUM_W-1:0]      nu, nv;
    logic                  div_u_busy, div_v_busy;
    logic [QUOT_W-1:0]     qu, qv;
    logic signed [4:0]     xc, yc, wx5, wy5;
    mirror_t               mx, my;
    logic [SUB_W-1:0]      ix, iy;
    logic [ADDR_W-1:0]     rd_addr;
    logic [1:0]            last_idx;
    logic                  term_last_x, term_last_y;
    logic [2*PT_W-1:0]     ram_q, rd_word;
    logic signed [PT_W-1:0] px, py;
    logic signed [22:0]    termx, termy;
    val_t                  sumx, sumy;
    interp_req_t           ireq;
    knots_t                isel;
    logic                  interp_busy, interp_done;
    val_t                  interp_res;
    logic                  inner_ph;
    logic                  satx_hi, satx_lo, saty_hi, saty_lo;
    logic signed [OUT_W-1:0] outx, outy;

    always_comb begin
        gc_eff = (grid_cols_reg == '0) ? GRID_W'(1) : grid_cols_reg;
        gr_eff = (grid_rows_reg == '0) ? GRID_W'(1) : grid_rows_reg;
        sx_eff = (subdiv_x_reg == '0) ? SUB_W'(1) : subdiv_x_reg;
        sy_eff = (subdiv_y_reg == '0) ? SUB_W'(1) : subdiv_y_reg;
        vc_eff = (s_vertex_col > gc_eff) ? gc_eff : s_vertex_col;
        vr_eff = (s_vertex_row > gr_eff) ? gr_eff : s_vertex_row;
        nu     = NUM_W'(vc_eff) * NUM_W'(sx_eff);
        nv     = NUM_W'(vr_eff) * NUM_W'(sy_eff);
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign eval_fire = s_fire && (s_action == ACT_EVAL);
    assign ram_we    = s_fire && (s_action == ACT_WRITE);
    assign rd_en     = (state_reg == ST_ISSUE);
    assign out_load  = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);
    assign last_idx  = cubic_mode_reg ? 2'd3 : 2'd1;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_cols_reg  <= GRID_W'(32);
            grid_rows_reg  <= GRID_W'(18);
            subdiv_x_reg   <= SUB_W'(1);
            subdiv_y_reg   <= SUB_W'(1);
            cubic_mode_reg <= 1'b1;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_GRID_COLS:  grid_cols_reg  <= cfg_wdata[GRID_W-1:0];
                REG_GRID_ROWS:  grid_rows_reg  <= cfg_wdata[GRID_W-1:0];
                REG_SUBDIV_X:   subdiv_x_reg   <= cfg_wdata[SUB_W-1:0];
                REG_SUBDIV_Y:   subdiv_y_reg   <= cfg_wdata[SUB_W-1:0];
                REG_CUBIC_MODE: cubic_mode_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Grid mapping: one division gives cell and fraction together, since
    // floor(n * 2^16 / g) is the cell in the top bits and the fraction below.
    wgbe_div u_div_u (
        .aclk(aclk), .aresetn(aresetn), .start(eval_fire), .num(nu), .den(gc_eff),
        .busy(div_u_busy), .quot(qu)
    );
    wgbe_div u_div_v (
        .aclk(aclk), .aresetn(aresetn), .start(eval_fire), .num(nv), .den(gr_eff),
        .busy(div_v_busy), .quot(qv)
    );

    // Knot position. Bicubic walks columns outside and rows inside, so each
    // column is first interpolated down with the row fraction. Bilinear
    // walks rows outside, interpolating across first.
    always_comb begin
        if (cubic_mode_reg) begin
            xc = $signed({2'b00, col_reg}) + $signed({3'b000, o_reg}) - 5'sd1;
            yc = $signed({2'b00, row_reg}) + $signed({3'b000, n_reg}) - 5'sd1;
        end else begin
            xc = $signed({2'b00, col_reg}) + $signed({3'b000, n_reg});
            yc = $signed({2'b00, row_reg}) + $signed({3'b000, o_reg});
        end
        mx          = mirror(xc, sx_eff);
        my          = mirror(yc, sy_eff);
        ix          = tx_reg ? mx.i1 : mx.i0;
        iy          = ty_reg ? my.i1 : my.i0;
        wx5         = 5'(tx_reg ? mx.w1 : mx.w0);
        wy5         = 5'(ty_reg ? my.w1 : my.w0);
        rd_addr     = ADDR_W'(ix) + ADDR_W'(iy) * ADDR_W'({1'b0, sx_eff} + 4'd1);
        term_last_x = (tx_reg == mx.two);
        term_last_y = (ty_reg == my.two);
    end

    wgbe_ram #(.WIDTH(2 * PT_W), .DEPTH(DEPTH)) u_store (
        .aclk(aclk), .we(ram_we), .waddr(s_point_index), .wdata({s_point_x, s_point_y}),
        .re(rd_en), .raddr(rd_addr), .rdata(ram_q)
    );

    // Entries never written since reset read as their reset value.
    always_comb begin
        rd_word = pv_reg ? ram_q : reset_point(p_addr_reg);
        px      = $signed(rd_word[2*PT_W-1:PT_W]);
        py      = $signed(rd_word[PT_W-1:0]);
        termx   = 23'(px) * 23'(p_w_reg);
        termy   = 23'(py) * 23'(p_w_reg);
        sumx    = (p_first_reg ? VAL_W'(0) : accx_reg) + VAL_W'(termx);
        sumy    = (p_first_reg ? VAL_W'(0) : accy_reg) + VAL_W'(termy);
    end

    always_comb begin
        inner_ph   = (state_reg == ST_INNER_X) || (state_reg == ST_INNER_Y);
        ireq.start = istart_reg;
        ireq.cubic = cubic_mode_reg;
        if (inner_ph) begin
            ireq.t = cubic_mode_reg ? fv_reg : fu_reg;
        end else begin
            ireq.t = cubic_mode_reg ? fu_reg : fv_reg;
        end
        case (state_reg)
            ST_INNER_X: isel = kx_reg;
            ST_INNER_Y: isel = ky_reg;
            ST_OUTER_X: isel = ax_reg;
            default:    isel = ay_reg;
        endcase
    end

    wgbe_interp u_interp (
        .aclk(aclk), .aresetn(aresetn), .req(ireq), .knots(isel),
        .busy(interp_busy), .done(interp_done), .result(interp_res)
    );

    // Saturation to the output range.
    always_comb begin
        satx_hi = (resx_reg > VAL_W'(OUT_MAX));
        satx_lo = (resx_reg < VAL_W'(OUT_MIN));
        saty_hi = (resy_reg > VAL_W'(OUT_MAX));
        saty_lo = (resy_reg < VAL_W'(OUT_MIN));
        outx    = satx_hi ? OUT_W'(OUT_MAX) : (satx_lo ? OUT_W'(OUT_MIN) : resx_reg[OUT_W-1:0]);
        outy    = saty_hi ? OUT_W'(OUT_MAX) : (saty_lo ? OUT_W'(OUT_MIN) : resy_reg[OUT_W-1:0]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            vld_reg     <= '0;
            p_valid_reg <= 1'b0;
            istart_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            o_reg       <= '0;
            n_reg       <= '0;
            tx_reg      <= 1'b0;
            ty_reg      <= 1'b0;
        end else begin
            istart_reg  <= 1'b0;
            p_valid_reg <= rd_en;
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (ram_we) begin
                vld_reg[s_point_index] <= 1'b1;
            end

            // Accumulate the weighted reads of one knot as they land.
            if (p_valid_reg) begin
                accx_reg <= sumx;
                accy_reg <= sumy;
                if (p_last_reg) begin
                    kx_reg[p_n_reg] <= sumx;
                    ky_reg[p_n_reg] <= sumy;
                end
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (eval_fire) begin
                        vnum_reg  <= VNUM_W'(vc_eff) +
                                     VNUM_W'(vr_eff) * VNUM_W'({1'b0, gc_eff} + 9'd1);
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (!div_u_busy && !div_v_busy) begin
                        col_reg   <= qu[QUOT_W-1:FRAC_BITS];
                        fu_reg    <= qu[FRAC_BITS-1:0];
                        row_reg   <= qv[QUOT_W-1:FRAC_BITS];
                        fv_reg    <= qv[FRAC_BITS-1:0];
                        o_reg     <= '0;
                        n_reg     <= '0;
                        tx_reg    <= 1'b0;
                        ty_reg    <= 1'b0;
                        state_reg <= ST_ISSUE;
                    end
                end
                ST_ISSUE: begin
                    p_first_reg <= !tx_reg && !ty_reg;
                    p_last_reg  <= term_last_x && term_last_y;
                    p_w_reg     <= wx5 * wy5;
                    p_n_reg     <= n_reg;
                    p_addr_reg  <= rd_addr;
                    pv_reg      <= vld_reg[rd_addr];
                    if (!term_last_x) begin
                        tx_reg <= 1'b1;
                    end else begin
                        tx_reg <= 1'b0;
                        if (!term_last_y) begin
                            ty_reg <= 1'b1;
                        end else begin
                            ty_reg <= 1'b0;
                            if (n_reg == last_idx) begin
                                state_reg <= ST_LAND;
                            end else begin
                                n_reg <= n_reg + 2'd1;
                            end
                        end
                    end
                end
                ST_LAND: begin
                    istart_reg <= 1'b1;
                    state_reg  <= ST_INNER_X;
                end
                ST_INNER_X: begin
                    if (interp_done) begin
                        ax_reg[o_reg] <= interp_res;
                        istart_reg    <= 1'b1;
                        state_reg     <= ST_INNER_Y;
                    end
                end
                ST_INNER_Y: begin
                    if (interp_done) begin
                        ay_reg[o_reg] <= interp_res;
                        if (o_reg == last_idx) begin
                            istart_reg <= 1'b1;
                            state_reg  <= ST_OUTER_X;
                        end else begin
                            o_reg     <= o_reg + 2'd1;
                            n_reg     <= '0;
                            state_reg <= ST_ISSUE;
                        end
                    end
                end
                ST_OUTER_X: begin
                    if (interp_done) begin
                        resx_reg   <= interp_res;
                        istart_reg <= 1'b1;
                        state_reg  <= ST_OUTER_Y;
                    end
                end
                ST_OUTER_Y: begin
                    if (interp_done) begin
                        resy_reg  <= interp_res;
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_load) begin
                        m_valid_reg <= 1'b1;
                        m_x_reg     <= outx;
                        m_y_reg     <= outy;
                        m_vnum_reg  <= vnum_reg;
                        m_sat_reg   <= satx_hi || satx_lo || saty_hi || saty_lo;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_warped_x      = m_x_reg;
    assign m_warped_y      = m_y_reg;
    assign m_vertex_number = m_vnum_reg;
    assign m_saturated     = m_sat_reg;

    `WGBE_ASSERT_NXT(a_eval_starts_div, aclk, aresetn, eval_fire, div_u_busy && div_v_busy, "evaluate beat did not start the divider")
    `WGBE_ASSERT_NXT(a_write_no_result, aclk, aresetn, ram_we && !m_valid_reg, !m_valid_reg, "write beat produced a result")
    `WGBE_ASSERT_IMP(a_interp_free, aclk, aresetn, istart_reg, !interp_busy, "interpolator started while busy")
endmodule

/* hw/rtl/wgbe_ram.sv */
`timescale 1ns / 1ps
module wgbe_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

/* hw/rtl/wgbe_div.sv */
`timescale 1ns / 1ps
module wgbe_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [wgbe_pkg::NUM_W-1:0]    num,
    input  logic [wgbe_pkg::GRID_W-1:0]   den,
    output logic                          busy,
    output logic [wgbe_pkg::QUOT_W-1:0]   quot
);
    import wgbe_pkg::*;

    localparam int DVD_W = NUM_W + FRAC_BITS;
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0]  dvd_reg;
    logic [GRID_W-1:0] rem_reg;
    logic [GRID_W-1:0] den_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic [GRID_W:0]   rsh;
    logic [GRID_W:0]   rdiff;
    logic              ge;

    // Restoring division, one quotient bit per cycle; the quotient
    // shifts into the dividend register from the bottom.
    always_comb begin
        rsh   = {rem_reg, dvd_reg[DVD_W-1]};
        rdiff = rsh - {1'b0, den_reg};
        ge    = (rsh >= {1'b0, den_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(DVD_W);
            dvd_reg  <= {num, {FRAC_BITS{1'b0}}};
            rem_reg  <= '0;
            den_reg  <= den;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], ge};
            rem_reg <= ge ? rdiff[GRID_W-1:0] : rsh[GRID_W-1:0];
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy = busy_reg;
    assign quot = dvd_reg[QUOT_W-1:0];
endmodule

/* hw/rtl/wgbe_interp.sv */
`timescale 1ns / 1ps
module wgbe_interp (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  wgbe_pkg::interp_req_t req,
    input  wgbe_pkg::knots_t      knots,
    output logic                  busy,
    output logic                  done,
    output wgbe_pkg::val_t        result
);
    import wgbe_pkg::*;

    localparam int PROD_W = VAL_W + FRAC_BITS + 1;
    localparam logic signed [PROD_W-1:0] HALF_F  = PROD_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [PROD_W-1:0] HALF_F1 = PROD_W'(1) <<< FRAC_BITS;

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_ADD} state_t;

    state_t                    state_reg;
    logic [1:0]                step_reg;
    logic                      cubic_reg;
    logic [FRAC_BITS-1:0]      t_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    val_t                      base_reg;
    val_t                      prev_reg;
    logic                      half_reg;
    logic                      last_reg;
    logic                      done_reg;

    val_t k0, k1, k2, k3, d12, c_v, b0_v, base_sel, x_sel;
    logic signed [PROD_W-1:0] prod_next, rnd_f, rnd_f1;

    // Catmull-Rom as three rounded multiply-adds (linear mode: one, k0 + t*(k1-k0)):
    // b = 2k0-5k1+4k2-k3 + t*c, a = k2-k0 + t*b, result = k1 + t*a/2.
    always_comb begin
        k0   = $signed(knots[0]);
        k1   = $signed(knots[1]);
        k2   = $signed(knots[2]);
        k3   = $signed(knots[3]);
        d12  = k1 - k2;
        c_v  = (d12 <<< 1) + d12 + k3 - k0;
        b0_v = (k0 <<< 1) - ((k1 <<< 2) + k1) + (k2 <<< 2) - k3;
        case (step_reg)
            2'd0: begin
                base_sel = cubic_reg ? b0_v : k0;
                x_sel    = cubic_reg ? c_v : (k1 - k0);
            end
            2'd1: begin
                base_sel = k2 - k0;
                x_sel    = prev_reg;
            end
            default: begin
                base_sel = k1;
                x_sel    = prev_reg;
            end
        endcase
        prod_next = PROD_W'(x_sel) * PROD_W'($signed({1'b0, t_reg}));
        rnd_f     = (prod_reg + HALF_F) >>> FRAC_BITS;
        rnd_f1    = (prod_reg + HALF_F1) >>> (FRAC_BITS + 1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            step_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (req.start) begin
                        cubic_reg <= req.cubic;
                        t_reg     <= req.t;
                        step_reg  <= '0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: begin
                    prod_reg  <= prod_next;
                    base_reg  <= base_sel;
                    half_reg  <= cubic_reg && (step_reg == 2'd2);
                    last_reg  <= !cubic_reg || (step_reg == 2'd2);
                    state_reg <= S_ADD;
                end
                S_ADD: begin
                    prev_reg <= base_reg + VAL_W'(half_reg ? rnd_f1 : rnd_f);
                    if (last_reg) begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end else begin
                        step_reg  <= step_reg + 2'd1;
                        state_reg <= S_MUL;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = prev_reg;
endmodule
